>>> hw/rtl/mfbs_pkg.sv
// Package for the memory feedback batch sizer.
// Holds word types, register indexes, fixed-point constants and the sequencer states.
// No dependencies.
package mfbs_pkg;

  localparam int unsigned BatchWidth = 16;
  localparam int unsigned UsageWidth = 15;
  localparam int unsigned FactWidth  = 17;   // unsigned Q1.16 factor
  localparam int unsigned QuotWidth  = 17;   // divider quotient bits
  localparam int unsigned CntWidth   = $clog2(QuotWidth);

  // Configuration register indexes
  localparam logic [1:0] CfgTarget = 2'd0;
  localparam logic [1:0] CfgLower  = 2'd1;
  localparam logic [1:0] CfgUpper  = 2'd2;

  // Reset values of the registers
  localparam logic [UsageWidth-1:0] TargetReset = 15'd20480;
  localparam logic [BatchWidth-1:0] LowerReset  = 16'd1;
  localparam logic [BatchWidth-1:0] UpperReset  = 16'd256;

  // 1/256 percent units
  localparam logic [UsageWidth-1:0] FullScale = 15'd25600;
  localparam logic [UsageWidth-1:0] HalfScale = 15'd12800;
  localparam logic signed [15:0]    TenPoints = 16'sd2560;

  // (25600 - excess) * 65536 / 25600 reduces to (25600 - excess) * 64 / 25
  localparam logic [UsageWidth-1:0] ShrinkDivisor = 15'd25;

  localparam logic [FactWidth-1:0] HalfQ16 = 17'd32768;
  localparam logic [FactWidth-1:0] OneQ16  = 17'd65536;
  localparam logic [FactWidth-1:0] CapQ16  = 17'd98304;

  typedef struct packed {
    logic [UsageWidth-1:0] usage_level;
    logic                  sample_size_known;
  } in_word_t;

  typedef struct packed {
    logic [BatchWidth-1:0] batch_size;
    logic                  adjust_advised;
  } out_word_t;

  typedef enum logic [1:0] {
    ModeHold,
    ModeShrink,
    ModeGrow
  } mode_e;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StMul,
    StDone
  } state_e;

endpackage

>>> hw/rtl/memory_feedback_batch_sizer.sv
// Memory feedback batch sizer, top level.
// Uses mfbs_pkg for word types, constants and sequencer states.
//
// Usage: each word on the input channel (in_valid_i/in_ready_o, in_data_i)
// carries a memory usage sample in 1/256 percent units. The block scales its
// kept batch size down when usage is above target, up when it is more than
// ten points below, clamps it to the limit registers and returns one word on
// the output channel (out_valid_o/out_ready_i, out_data_o) per input word.
// Registers are written through cfg_valid_i/cfg_ready_o, cfg_index_i,
// cfg_data_i; write them only while the block is idle. A limit change shows
// at the next sample.
// When the batch is scaled, the sample passes 17 steps of the shared restoring
// divider, one multiply and one clamp; when it only clamps, it goes straight
// to the clamp. One sample is in work at a time: the sequencer returns to idle
// before it takes the next, so a new word is accepted only when the last one
// is through, and the divider loop is the longest part of the work per word.
// The next sample is accepted while a finished result waits at the output;
// a stalled receiver holds the sequencer in its last step until the output
// register frees up. Reset loads the register reset values, sets the batch
// to 1 and empties the output.
module memory_feedback_batch_sizer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mfbs_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mfbs_pkg::out_word_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  localparam int unsigned BW = mfbs_pkg::BatchWidth;
  localparam int unsigned UW = mfbs_pkg::UsageWidth;
  localparam int unsigned FW = mfbs_pkg::FactWidth;
  localparam int unsigned QW = mfbs_pkg::QuotWidth;
  localparam int unsigned CW = mfbs_pkg::CntWidth;

  mfbs_pkg::state_e state_q, state_d;
  mfbs_pkg::mode_e  mode_q, mode_d;

  logic [UW-1:0] target_q;
  logic [BW-1:0] lower_q, upper_q;
  logic [BW-1:0] batch_q, batch_d;

  logic          known_q, known_d;
  logic          big_q, big_d;
  logic          adjust_q, adjust_d;

  logic [UW-1:0] rem_q, rem_d;
  logic [QW-1:0] num_q, num_d;     // dividend bits in, quotient bits out
  logic [UW-1:0] div_q, div_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [FW-1:0] prod_q, prod_d;

  logic          out_valid_q, out_valid_d;
  mfbs_pkg::out_word_t out_q, out_d;

  logic                accept;
  logic                out_free;
  logic signed [15:0]  diff;
  logic [UW-1:0]       excess, head, shrink_base;
  logic [31:0]         dividend;
  logic [UW:0]         trial;
  logic                qbit;
  logic [FW:0]         grow_sum;
  logic [FW-1:0]       grow_f, mem_f, factor;
  logic [BW+FW-1:0]    product;
  logic [FW-1:0]       clamped;

  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == mfbs_pkg::StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sample decode
  assign diff   = $signed({1'b0, in_data_i.usage_level}) - $signed({1'b0, target_q});
  assign excess = diff[UW-1:0];
  assign head   = target_q - in_data_i.usage_level;
  assign shrink_base = mfbs_pkg::FullScale - excess;

  // Divider step: one quotient bit per cycle
  assign trial = {rem_q, num_q[QW-1]};
  assign qbit  = (trial >= {1'b0, div_q});

  // Factor selection from the quotient
  assign grow_sum = {1'b0, mfbs_pkg::OneQ16} + {1'b0, num_q};
  assign grow_f   = (grow_sum > {1'b0, mfbs_pkg::CapQ16}) ? mfbs_pkg::CapQ16
                                                          : grow_sum[FW-1:0];
  assign mem_f    = mfbs_pkg::OneQ16 + {1'b0, num_q[QW-1:1]};

  always_comb begin
    factor = grow_f;
    case (mode_q)
      mfbs_pkg::ModeShrink: begin
        if (big_q || num_q < mfbs_pkg::HalfQ16) begin
          factor = mfbs_pkg::HalfQ16;
        end else begin
          factor = num_q;
        end
      end
      mfbs_pkg::ModeGrow: begin
        if (known_q && mem_f < grow_f) begin
          factor = mem_f;
        end else begin
          factor = grow_f;
        end
      end
      default: factor = grow_f;
    endcase
  end

  assign product = {{FW{1'b0}}, batch_q} * {{BW{1'b0}}, factor};

  // Final clamp: upper limit first, then lower
  always_comb begin
    clamped = prod_q;
    if (clamped > {1'b0, upper_q}) begin
      clamped = {1'b0, upper_q};
    end
    if (clamped < {1'b0, lower_q}) begin
      clamped = {1'b0, lower_q};
    end
  end

  // Dividend for the divider load
  always_comb begin
    if (diff > 16'sd0) begin
      dividend = {11'b0, shrink_base, 6'b0};
    end else begin
      dividend = {1'b0, head, 16'b0};
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mfbs_pkg::StIdle: begin
        if (accept) begin
          if (diff > 16'sd0 || diff < -mfbs_pkg::TenPoints) begin
            state_d = mfbs_pkg::StDiv;
          end else begin
            state_d = mfbs_pkg::StDone;
          end
        end
      end
      mfbs_pkg::StDiv: begin
        if (cnt_q == CW'(QW - 1)) begin
          state_d = mfbs_pkg::StMul;
        end
      end
      mfbs_pkg::StMul:  state_d = mfbs_pkg::StDone;
      mfbs_pkg::StDone: begin
        if (out_free) begin
          state_d = mfbs_pkg::StIdle;
        end
      end
      default: state_d = mfbs_pkg::StIdle;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    mode_d      = mode_q;
    known_d     = known_q;
    big_d       = big_q;
    adjust_d    = adjust_q;
    rem_d       = rem_q;
    num_d       = num_q;
    div_d       = div_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    batch_d     = batch_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      mfbs_pkg::StIdle: begin
        if (accept) begin
          known_d  = in_data_i.sample_size_known;
          big_d    = (excess >= mfbs_pkg::HalfScale);
          adjust_d = (diff > mfbs_pkg::TenPoints) || (diff < -mfbs_pkg::TenPoints);
          rem_d    = dividend[31:QW];
          num_d    = dividend[QW-1:0];
          cnt_d    = '0;
          prod_d   = {1'b0, batch_q};
          if (diff > 16'sd0) begin
            mode_d = mfbs_pkg::ModeShrink;
            div_d  = mfbs_pkg::ShrinkDivisor;
          end else if (diff < -mfbs_pkg::TenPoints) begin
            mode_d = mfbs_pkg::ModeGrow;
            div_d  = target_q;
          end else begin
            mode_d = mfbs_pkg::ModeHold;
          end
        end
      end
      mfbs_pkg::StDiv: begin
        rem_d = qbit ? UW'(trial - {1'b0, div_q}) : trial[UW-1:0];
        num_d = {num_q[QW-2:0], qbit};
        cnt_d = cnt_q + CW'(1);
      end
      mfbs_pkg::StMul: begin
        prod_d = product[BW+FW-1:16];
      end
      mfbs_pkg::StDone: begin
        if (out_free) begin
          batch_d                = clamped[BW-1:0];
          out_d.batch_size       = clamped[BW-1:0];
          out_d.adjust_advised   = adjust_q;
          out_valid_d            = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= mfbs_pkg::TargetReset;
      lower_q  <= mfbs_pkg::LowerReset;
      upper_q  <= mfbs_pkg::UpperReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mfbs_pkg::CfgTarget: target_q <= cfg_data_i[UW-1:0];
        mfbs_pkg::CfgLower:  lower_q  <= cfg_data_i;
        mfbs_pkg::CfgUpper:  upper_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfbs_pkg::StIdle;
      mode_q      <= mfbs_pkg::ModeHold;
      cnt_q       <= '0;
      batch_q     <= mfbs_pkg::LowerReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      cnt_q       <= cnt_d;
      batch_q     <= batch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    known_q  <= known_d;
    big_q    <= big_d;
    adjust_q <= adjust_d;
    rem_q    <= rem_d;
    num_q    <= num_d;
    div_q    <= div_d;
    prod_q   <= prod_d;
    out_q    <= out_d;
  end

endmodule
